[rtl/core/assert_macros.svh]
// Assertion macros for the checker of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/nabs_pkg.sv]
// Shared types and constants for the nearest angle bin search block.
// No dependencies.
package nabs_pkg;

  localparam int ANGLE_W = 16;   // signed angle, 1 LSB = 2^-13 rad
  localparam int IDX_W   = 10;   // entry index field
  localparam int CFG_W   = 11;   // entries_in_use register
  localparam int OPND_W  = 18;   // comparator operand width
  localparam int DIFF_W  = OPND_W + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // shared compare unit outputs
  typedef struct packed {
    logic              lt;    // a <  b
    logic              le;    // a <= b
    logic [DIFF_W-1:0] diff;  // a - b, signed
  } cmp_res_t;

endpackage

[rtl/core/nearest_angle_bin_search.sv]
// Top level of the nearest angle bin search: sequencer, config register, output stage.
// Depends on nabs_pkg, nabs_cmp, nabs_ram.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata: entry_index, angle_value; tuser: opcode
//  out_    | out | out_tvalid/out_tready | tdata: nearest_index
//  cfg_    | in  | cfg_wr_en             | cfg_wr_data: entries_in_use
//
// A load writes the table and leaves the sequencer idle. A query makes two
// endpoint reads, one table read per search step, two neighbor reads and a
// distance compare, all through the one table read port and the one compare
// unit. A query that lands before the first entry or past the last skips the
// neighbor reads and the distance compare.
// in_tready is high only while the sequencer is idle; a result still waiting in
// the output register holds the sequencer in its last state until it is taken.
// Reset (rst_n low, synchronous) idles the sequencer, drops out_tvalid and sets
// entries_in_use to 1024. The table is not cleared.
module nearest_angle_bin_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [9:0] entry_index, [25:10] angle_value, [31:26] zero
  input  logic        in_tuser,    // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [9:0] nearest_index, [15:10] zero
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data  // entries_in_use
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AWD = nabs_pkg::ANGLE_W;
  localparam int OW  = nabs_pkg::OPND_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_END   = 4'd4;
  localparam logic [3:0] S_FND   = 4'd5;
  localparam logic [3:0] S_PRV   = 4'd6;
  localparam logic [3:0] S_PICK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [nabs_pkg::CFG_W-1:0] cfg_r;
  logic [CW-1:0] n_r, n_nxt, n_clamp;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0] found_r, found_nxt, pick_r, pick_nxt;
  logic [CW:0]   mid_sum;
  logic          asc_r, asc_nxt;
  logic signed [AWD-1:0] q_r, q_nxt, first_r, first_nxt;
  logic [AWD:0]  dn_r, dn_nxt, dp_r, dp_nxt, abs_w;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [nabs_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic [nabs_pkg::IDX_W-1:0] in_idx;
  logic signed [AWD-1:0]      in_angle;
  logic                       in_xfer, load_ok;
  logic [31:0]                cfg_ext;

  logic                  wr_en;
  logic [AW-1:0]         rd_addr;
  logic signed [AWD-1:0] rd_data;
  logic [CW-1:0]         srch_addr;

  logic signed [OW-1:0]  cmp_a, cmp_b;
  logic signed [nabs_pkg::DIFF_W-1:0] neg_diff;
  nabs_pkg::cmp_res_t    cmp_res;

  assign in_idx    = in_tdata[9:0];
  assign in_angle  = in_tdata[25:10];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign load_ok   = (32'(in_idx) < 32'(TABLE_DEPTH));
  assign wr_en     = in_xfer && (in_tuser == nabs_pkg::OP_LOAD) && load_ok;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_idx_r};

  // clamp the entry count into 1..TABLE_DEPTH
  assign cfg_ext = 32'(cfg_r);
  always_comb begin
    priority if (cfg_ext == 32'd0) begin
      n_clamp = CW'(1);
    end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = CW'(cfg_ext);
    end
  end

  nabs_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_idx)),
    .wr_data (in_angle),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nabs_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // operand select for the shared compare unit
  always_comb begin
    unique case (state_r)
      S_LAST: begin
        cmp_a = {{(OW-AWD){first_r[AWD-1]}}, first_r};
        cmp_b = {{(OW-AWD){rd_data[AWD-1]}}, rd_data};
      end
      S_PICK: begin
        cmp_a = {{(OW-AWD-1){1'b0}}, dn_r};
        cmp_b = {{(OW-AWD-1){1'b0}}, dp_r};
      end
      default: begin
        cmp_a = {{(OW-AWD){rd_data[AWD-1]}}, rd_data};
        cmp_b = {{(OW-AWD){q_r[AWD-1]}}, q_r};
      end
    endcase
  end

  // |entry - query|, fits in ANGLE_W+1 bits
  assign neg_diff = -cmp_res.diff;
  assign abs_w = cmp_res.diff[nabs_pkg::DIFF_W-1] ? neg_diff[AWD:0] : cmp_res.diff[AWD:0];

  // next search midpoint and its table address
  assign mid_sum   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt   = mid_sum[CW:1];
  assign srch_addr = asc_nxt ? mid_nxt : (n_r - CW'(1) - mid_nxt);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    asc_nxt        = asc_r;
    q_nxt          = q_r;
    first_nxt      = first_r;
    dn_nxt         = dn_r;
    dp_nxt         = dp_r;
    out_idx_nxt    = out_idx_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_tuser == nabs_pkg::OP_QUERY)) begin
          q_nxt     = in_angle;
          n_nxt     = n_clamp;
          rd_addr   = '0;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        first_nxt = rd_data;
        rd_addr   = AW'(n_r - CW'(1));
        state_nxt = S_LAST;
      end
      S_LAST: begin
        // first < last means ascending
        asc_nxt   = cmp_res.lt;
        lo_nxt    = '0;
        hi_nxt    = n_r;
        rd_addr   = AW'(srch_addr);
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (cmp_res.le) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        rd_addr = AW'(srch_addr);
        if (lo_nxt >= hi_nxt) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        found_nxt = asc_r ? lo_r : (n_r - lo_r);
        priority if (found_nxt == '0) begin
          pick_nxt  = '0;
          state_nxt = S_DONE;
        end else if (found_nxt >= n_r) begin
          pick_nxt  = n_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          rd_addr   = AW'(found_nxt);
          state_nxt = S_FND;
        end
      end
      S_FND: begin
        dn_nxt    = abs_w;
        rd_addr   = AW'(found_r - CW'(1));
        state_nxt = S_PRV;
      end
      S_PRV: begin
        // distance to the previous entry
        dp_nxt    = abs_w;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        // found entry wins only when strictly closer
        pick_nxt  = cmp_res.lt ? found_r : (found_r - CW'(1));
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_idx_nxt    = nabs_pkg::IDX_W'(pick_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      cfg_r        <= nabs_pkg::CFG_RESET;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    found_r   <= found_nxt;
    pick_r    <= pick_nxt;
    asc_r     <= asc_nxt;
    q_r       <= q_nxt;
    first_r   <= first_nxt;
    dn_r      <= dn_nxt;
    dp_r      <= dp_nxt;
    out_idx_r <= out_idx_nxt;
  end

endmodule

[rtl/core/nabs_cmp.sv]
// Shared signed subtract/compare unit for the search sequencer.
// Depends on nabs_pkg.
module nabs_cmp (
  input  logic signed [nabs_pkg::OPND_W-1:0] a,
  input  logic signed [nabs_pkg::OPND_W-1:0] b,
  output nabs_pkg::cmp_res_t                 res
);

  logic signed [nabs_pkg::DIFF_W-1:0] diff_w;

  // one subtractor; sign and zero give both orderings
  always_comb begin
    diff_w   = {a[nabs_pkg::OPND_W-1], a} - {b[nabs_pkg::OPND_W-1], b};
    res.diff = diff_w;
    res.lt   = diff_w[nabs_pkg::DIFF_W-1];
    res.le   = diff_w[nabs_pkg::DIFF_W-1] || (diff_w == '0);
  end

endmodule

[rtl/core/nabs_ram.sv]
// Angle table storage: one write port, one registered read port.
// Depends on nabs_pkg.
module nabs_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [nabs_pkg::ANGLE_W-1:0] wr_data,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [nabs_pkg::ANGLE_W-1:0] rd_data
);

  logic signed [nabs_pkg::ANGLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/nabs_checker.sv]
// Port-level checker for nearest_angle_bin_search, bound to the top level.
// Depends on assert_macros.svh and nabs_pkg.
`include "assert_macros.svh"

module nabs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // a query transfer makes the block busy
  `ASSERT_NEXT(a_query_busy, clk, rst_n, in_xfer && (in_tuser == nabs_pkg::OP_QUERY), !in_tready)
  // a load transfer leaves the block ready again in the next cycle
  `ASSERT_NEXT(a_load_fast, clk, rst_n, in_xfer && (in_tuser == nabs_pkg::OP_LOAD), in_tready)
  // a new result appears only at the end of a busy period
  `ASSERT_IMPLY(a_result_after_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready))

endmodule

bind nearest_angle_bin_search nabs_checker u_nabs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
